// ===== sv/dxt5_block_decoder_defines.svh =====
// assertion macros shared by the rtl
`ifndef DXT5_BLOCK_DECODER_DEFINES_SVH
`define DXT5_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define DXT5_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define DXT5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/dxt5_pkg.sv =====
`default_nettype none

package dxt5_pkg;

	// block geometry
	localparam int unsigned PixelCount = 16;
	localparam logic [3:0] LastPixel = 4'd15;

	// reciprocal multipliers, exact over the value ranges that occur
	localparam int unsigned Div3Mul   = 683;
	localparam int unsigned Div3Shift = 11;
	localparam int unsigned Div5Mul   = 1639;
	localparam int unsigned Div5Shift = 13;
	localparam int unsigned Div7Mul   = 2341;
	localparam int unsigned Div7Shift = 14;

	// fixed alpha entries of the six-entry (four-blend) mode
	localparam logic [7:0] AlphaZero = 8'd0;
	localparam logic [7:0] AlphaFull = 8'd255;

	typedef logic [2:0][7:0] rgb_t;
	typedef logic [3:0][2:0][7:0] color_pal_t;
	typedef logic [7:0][7:0] alpha_pal_t;

	// 5-bit channel to 8 bits by replication
	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	// 6-bit channel to 8 bits by replication
	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// x / 3 for x <= 766
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] p;
		p = 21'(x) * 21'(Div3Mul);
		return p[Div3Shift +: 8];
	endfunction

	// x / 5 for x <= 1277
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'(Div5Mul);
		return p[Div5Shift +: 8];
	endfunction

	// x / 7 for x <= 1788
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(Div7Mul);
		return p[Div7Shift +: 8];
	endfunction

endpackage

`default_nettype wire

// ===== sv/dxt5_block_decoder.sv =====
// channel | handshake            | payload
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_ready  | alpha_word[63:0], color_word[63:0]
// out     | out_valid / out_ready| pixel_index, red, green, blue, opacity,
//         |                      | last_pixel
//
// each block gives 16 pixels, one per cycle while out_ready does not stall the
// output; the pixel counter on the palette stage steps through them.
// an accepted block passes the input register, palette stage and output register.
// arst_n clears all valid bits and the pixel counter; payload is not reset.
// a stalled output holds its pixel; the next block waits in the input register
// and enters the palette stage the cycle the last pixel of the current one moves on.

`default_nettype none
`include "dxt5_block_decoder_defines.svh"

module dxt5_block_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] alpha_word,
	input  wire logic [63:0] color_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       pixel_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       opacity,
	output logic             last_pixel
);

	import dxt5_pkg::*;

	// input register
	logic        valid_s1;
	logic [63:0] aw_s1;
	logic [63:0] cw_s1;

	// palette stage
	logic        valid_s2;
	color_pal_t  cpal_s2;
	alpha_pal_t  apal_s2;
	logic [31:0] cidx_s2;
	logic [47:0] aidx_s2;
	logic [3:0]  cnt_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  pixel_index_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [7:0]  opacity_q;
	logic        last_pixel_q;

	// decode signals
	rgb_t        ep0;
	rgb_t        ep1;
	color_pal_t  cpal_d;
	alpha_pal_t  apal_d;
	logic [7:0]  a0;
	logic [7:0]  a1;
	logic [1:0]  ci;
	logic [2:0]  ai;
	logic        last;
	logic        adv;
	logic        s2_free;
	logic        load_s2;

	// flow control
	assign last     = (cnt_q == LastPixel);
	assign adv      = valid_s2 && (!out_valid_q || out_ready);
	assign s2_free  = !valid_s2 || (adv && last);
	assign load_s2  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || load_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			aw_s1 <= alpha_word;
			cw_s1 <= color_word;
		end
	end

	// color endpoints, rgb565 widened to 8 bits
	always_comb begin
		ep0[0] = widen5(cw_s1[15:11]);
		ep0[1] = widen6(cw_s1[10:5]);
		ep0[2] = widen5(cw_s1[4:0]);
		ep1[0] = widen5(cw_s1[31:27]);
		ep1[1] = widen6(cw_s1[26:21]);
		ep1[2] = widen5(cw_s1[20:16]);
	end

	// color palette: endpoints and the 1/3, 2/3 blends
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			cpal_d[0][ch] = ep0[ch];
			cpal_d[1][ch] = ep1[ch];
			cpal_d[2][ch] = div3({1'b0, ep0[ch], 1'b0} + {2'b00, ep1[ch]} + 10'd1);
			cpal_d[3][ch] = div3({2'b00, ep0[ch]} + {1'b0, ep1[ch], 1'b0} + 10'd1);
		end
	end

	// alpha palette: eight-entry or six-entry mode
	assign a0 = aw_s1[7:0];
	assign a1 = aw_s1[15:8];

	always_comb begin
		apal_d[0] = a0;
		apal_d[1] = a1;
		for (int k = 2; k < 8; k++) begin
			if (a0 > a1) begin
				apal_d[k] = div7(11'(32'(8 - k) * 32'(a0) + 32'(k - 1) * 32'(a1) + 32'd3));
			end else if (k < 6) begin
				apal_d[k] = div5(11'(32'(6 - k) * 32'(a0) + 32'(k - 1) * 32'(a1) + 32'd2));
			end else if (k == 6) begin
				apal_d[k] = AlphaZero;
			end else begin
				apal_d[k] = AlphaFull;
			end
		end
	end

	// palette stage and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			cpal_s2 <= cpal_d;
			apal_s2 <= apal_d;
			cidx_s2 <= cw_s1[63:32];
			aidx_s2 <= aw_s1[63:16];
		end
	end

	// per-pixel index select
	assign ci = cidx_s2[2 * cnt_q +: 2];
	assign ai = aidx_s2[3 * cnt_q +: 3];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_index_q <= cnt_q;
			red_q         <= cpal_s2[ci][0];
			green_q       <= cpal_s2[ci][1];
			blue_q        <= cpal_s2[ci][2];
			opacity_q     <= apal_s2[ai];
			last_pixel_q  <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign opacity     = opacity_q;
	assign last_pixel  = last_pixel_q;

	// checks
	`DXT5_ASSERT_IMPL(a_idle_cnt_zero, clk, arst_n, !valid_s2, cnt_q == 4'd0)
	`DXT5_ASSERT_IMPL(a_last_is_15, clk, arst_n, out_valid && last_pixel, pixel_index == LastPixel)
	`DXT5_ASSERT_NEXT(a_block_continues, clk, arst_n, out_valid && out_ready && !last_pixel, out_valid)
	`DXT5_ASSERT_NEXT(a_index_steps, clk, arst_n, out_valid && out_ready && !last_pixel, pixel_index == $past(pixel_index) + 4'd1)
	`DXT5_ASSERT_NEXT(a_block_restarts, clk, arst_n, out_valid && out_ready && last_pixel, !out_valid || pixel_index == 4'd0)

endmodule

`default_nettype wire
